>>> rtl/heightmap_brush_stamp_engine_defines.svh
// Assertion macros for the brush stamp engine.
`ifndef HEIGHTMAP_BRUSH_STAMP_ENGINE_DEFINES_SVH
`define HEIGHTMAP_BRUSH_STAMP_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
`define HBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HBS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HBS_ASSERT(lbl, prop, msg)
`define HBS_ASSERT_RST(lbl, prop, msg)
`endif
`endif

>>> rtl/hbs_pkg.sv
// Shared types and constants of the brush stamp engine.
`timescale 1ns / 1ps
package hbs_pkg;
  localparam int MapWidthDef  = 256;
  localparam int MapHeightDef = 256;
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_STAMP = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_RADIUS = 3'd1;
  localparam logic [2:0] REG_HSTR = 3'd2;
  localparam logic [2:0] REG_BSTR = 3'd3;
  localparam logic [2:0] REG_BTGT = 3'd4;
  localparam logic [2:0] REG_HSCL = 3'd5;
  localparam logic [2:0] REG_CLRH = 3'd6;
  localparam logic [2:0] REG_CLRB = 3'd7;
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  typedef struct packed {
    logic       start_clear;
    logic       start_stamp;
    logic       start_query;
  } cmd_t;

  typedef struct packed {
    logic       walk_done;
    logic       query_done;
  } sts_t;
endpackage

>>> rtl/hbs_ctrl.sv
// Sequencing controller of the brush stamp engine.
`timescale 1ns / 1ps
`include "heightmap_brush_stamp_engine_defines.svh"
module hbs_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [1:0]     in_operation,
  input  logic           radius_zero,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [1:0]     kind,
  output logic           applied,
  output hbs_pkg::cmd_t  cmd,
  input  hbs_pkg::sts_t  sts
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_BUSY = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;
  localparam logic [1:0] S_INIT = 2'd3;
  logic [1:0] state_r, state_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic       app_r, app_nxt;
  logic       take;

  assign in_stall = (state_r != S_IDLE);
  assign take = in_valid && !in_stall;
  assign out_valid = (state_r == S_OUT);
  assign kind = kind_r;
  assign applied = app_r;

  always_comb begin
    state_nxt = state_r;
    kind_nxt = kind_r;
    app_nxt = app_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (take) begin
          kind_nxt = in_operation;
          case (in_operation)
            hbs_pkg::OP_CLEAR: begin
              cmd.start_clear = 1'b1; app_nxt = 1'b1; state_nxt = S_BUSY;
            end
            hbs_pkg::OP_STAMP: begin
              app_nxt = !radius_zero;
              if (radius_zero) state_nxt = S_OUT;
              else begin
                cmd.start_stamp = 1'b1; state_nxt = S_BUSY;
              end
            end
            hbs_pkg::OP_QUERY: begin
              cmd.start_query = 1'b1; app_nxt = 1'b1; state_nxt = S_BUSY;
            end
            default: begin
              app_nxt = 1'b0; state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_BUSY: begin
        if (sts.walk_done || sts.query_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      // zeroing pass after reset, no result
      S_INIT: begin
        if (sts.walk_done) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      kind_r <= 2'd0;
      app_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      kind_r <= kind_nxt;
      app_r <= app_nxt;
    end
  end

  `HBS_ASSERT(a_no_take_busy, (state_r != S_IDLE) |-> in_stall, "accept while busy")
  `HBS_ASSERT(a_out_holds, (out_valid && out_stall) |=> (out_valid && $stable(kind_r)),
    "result dropped")
  `HBS_ASSERT(a_done_busy, (sts.walk_done || sts.query_done) |-> (state_r == S_BUSY || state_r == S_INIT),
    "done outside busy")
endmodule

>>> rtl/hbs_sqrt.sv
// Iterative root and radius division unit: yields the normalized distance.
`timescale 1ns / 1ps
module hbs_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [17:0] dist_sq,
  input  logic [8:0]  radius,
  output logic        done,
  output logic [16:0] dist_norm
);
  // root of dist_sq<<32: 25-bit result, one bit per cycle; then q/r, one bit per cycle
  logic [49:0] rem_r, rem_nxt;
  logic [24:0] root_r, root_nxt;
  logic [49:0] n_r, n_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        phase_r, phase_nxt, busy_r, busy_nxt;
  logic [24:0] drem_r, drem_nxt;
  logic [24:0] quo_r, quo_nxt;
  logic [51:0] trial;
  logic [25:0] dtrial;

  always_comb begin
    rem_nxt = rem_r; root_nxt = root_r; n_nxt = n_r; cnt_nxt = cnt_r;
    phase_nxt = phase_r; busy_nxt = busy_r; drem_nxt = drem_r; quo_nxt = quo_r;
    done = 1'b0;
    trial = '0;
    dtrial = '0;
    if (start) begin
      n_nxt = {dist_sq, 32'd0};
      rem_nxt = '0; root_nxt = '0; cnt_nxt = 6'd25; phase_nxt = 1'b0; busy_nxt = 1'b1;
    end else if (busy_r && !phase_r) begin
      trial = {rem_r, n_r[49:48]} - {25'd0, root_r, 2'b01};
      if (!trial[51]) begin
        rem_nxt = trial[49:0]; root_nxt = {root_r[23:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[47:0], n_r[49:48]}; root_nxt = {root_r[23:0], 1'b0};
      end
      n_nxt = {n_r[47:0], 2'b00};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        phase_nxt = 1'b1; cnt_nxt = 6'd25; drem_nxt = '0;
        quo_nxt = !trial[51] ? {root_r[23:0], 1'b1} : {root_r[23:0], 1'b0};
      end
    end else if (busy_r) begin
      dtrial = {drem_r, quo_r[24]} - {17'd0, radius};
      if (!dtrial[25]) begin
        drem_nxt = dtrial[24:0]; quo_nxt = {quo_r[23:0], 1'b1};
      end else begin
        drem_nxt = {drem_r[23:0], quo_r[24]}; quo_nxt = {quo_r[23:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0; done = 1'b1;
      end
    end
  end

  // quotient never exceeds 65536 since dist_sq <= r*r
  assign dist_norm = (quo_r[24:17] != 8'd0) ? hbs_pkg::ONE_Q16 : quo_r[16:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; phase_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; phase_r <= phase_nxt; cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt; root_r <= root_nxt; n_r <= n_nxt;
    drem_r <= drem_nxt; quo_r <= quo_nxt;
  end
endmodule

>>> rtl/hbs_datapath.sv
// Map storage, pixel walk and the per-pixel arithmetic of the brush engine.
`timescale 1ns / 1ps
module hbs_datapath #(
  parameter int MAP_WIDTH  = hbs_pkg::MapWidthDef,
  parameter int MAP_HEIGHT = hbs_pkg::MapHeightDef
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hbs_pkg::cmd_t        cmd,
  output hbs_pkg::sts_t        sts,
  input  logic [16:0]          pos_u,
  input  logic [16:0]          pos_v,
  input  logic                 lower,
  input  logic                 mode,
  input  logic [8:0]           radius,
  input  logic [16:0]          h_str,
  input  logic [16:0]          b_str,
  input  logic [16:0]          b_tgt,
  input  logic signed [24:0]   h_scl,
  input  logic signed [31:0]   clr_h,
  input  logic [16:0]          clr_b,
  output logic signed [47:0]   height_value
);
  localparam int XW = $clog2(MAP_WIDTH);
  localparam int YW = $clog2(MAP_HEIGHT);
  localparam int CELLS = MAP_WIDTH * MAP_HEIGHT;
  localparam int AW = $clog2(CELLS);
  localparam logic [XW-1:0] XMAX = XW'(MAP_WIDTH - 1);
  localparam logic [YW-1:0] YMAX = YW'(MAP_HEIGHT - 1);

  // phases of the clear pass, the pixel walk and the query
  localparam logic [3:0] P_IDLE = 4'd0, P_CLR = 4'd1, P_PIX = 4'd2, P_SQ = 4'd3,
    P_RD = 4'd4, P_F1 = 4'd5, P_F2 = 4'd6, P_F3 = 4'd7, P_WR = 4'd8,
    P_Q1 = 4'd9, P_Q2 = 4'd10, P_Q3 = 4'd11, P_NEXT = 4'd12, P_SQW = 4'd13,
    P_B2 = 4'd14;

  logic signed [31:0] hmem [CELLS];
  logic [16:0]        bmem [CELLS];

  logic [3:0]  ph_r, ph_nxt;
  logic [AW-1:0] clr_r;
  logic        init_r;
  logic [XW-1:0] cx_r, x_r, x0_r, x1_r;
  logic [YW-1:0] cy_r, y_r, y1_r;
  logic [AW-1:0] addr_r;
  logic signed [31:0] hrd_r;
  logic [16:0] brd_r;
  logic [17:0] s_r;
  logic [16:0] f_r;
  logic [33:0] t_r;
  logic [16:0] g_r;
  logic [63:0] p_r;
  logic signed [47:0] hv_r;
  logic        sq_start;
  logic        sq_done;
  logic [16:0] dn;
  logic signed [31:0] hwr;
  logic [16:0] bwr;
  logic        ahead;
  logic        lo_r;

  hbs_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .start(sq_start), .dist_sq(s_r),
    .radius(radius), .done(sq_done), .dist_norm(dn));

  function automatic logic [12:0] to_pix(input logic [16:0] p, input int sz);
    logic [16:0] c;
    logic [29:0] m;
    begin
      c = (p > hbs_pkg::ONE_Q16) ? hbs_pkg::ONE_Q16 : p;
      m = 30'(c) * 30'(sz - 1);
      to_pix = m[28:16];
    end
  endfunction

  logic [12:0] px, py;
  logic signed [13:0] xl, xh, yl, yh;
  logic signed [13:0] dx, dy;
  logic [25:0] rr;
  assign px = to_pix(pos_u, MAP_WIDTH);
  assign py = to_pix(pos_v, MAP_HEIGHT);
  assign xl = $signed({1'b0, px}) - $signed({5'd0, radius});
  assign xh = $signed({1'b0, px}) + $signed({5'd0, radius});
  assign yl = $signed({1'b0, py}) - $signed({5'd0, radius});
  assign yh = $signed({1'b0, py}) + $signed({5'd0, radius});
  assign dx = $signed({1'b0, 13'(x_r)}) - $signed({1'b0, 13'(cx_r)});
  assign dy = $signed({1'b0, 13'(y_r)}) - $signed({1'b0, 13'(cy_r)});
  assign rr = 26'(radius) * 26'(radius);

  // falloff and update arithmetic
  logic [17:0] k3;
  logic signed [49:0] hsum;
  logic signed [17:0] diff;
  logic [17:0] dmag;
  logic [48:0] stepm;
  logic signed [49:0] bsum;
  always_comb begin
    k3 = 18'd196608 - {f_r, 1'b0};
    hsum = 50'(hrd_r) + (lo_r ? -$signed({18'd0, p_r[47:16]}) : $signed({18'd0, p_r[47:16]}));
    diff = $signed({1'b0, b_tgt}) - $signed({1'b0, brd_r});
    dmag = diff[17] ? 18'(-diff) : 18'(diff);
    stepm = 49'(p_r[63:32]);
    bsum = diff[17] ? 50'(brd_r) - 50'(stepm) : 50'(brd_r) + 50'(stepm);
    hwr = (hsum > 50'sd2147483647) ? 32'sh7fffffff :
          (hsum < -50'sd2147483648) ? 32'sh80000000 : hsum[31:0];
    bwr = bsum[49] ? 17'd0 : (bsum > 50'sd65536) ? hbs_pkg::ONE_Q16 : bsum[16:0];
  end

  logic [47:0] hmag;
  logic [24:0] smag;
  logic neg_r;
  logic [63:0] qprod_r;

  always_comb begin
    ph_nxt = ph_r;
    sq_start = 1'b0;
    sts = '0;
    ahead = 1'b0;
    case (ph_r)
      P_IDLE: begin
        if (cmd.start_clear) ph_nxt = P_CLR;
        else if (cmd.start_stamp) ph_nxt = P_PIX;
        else if (cmd.start_query) ph_nxt = P_Q1;
      end
      P_CLR: if (clr_r == AW'(CELLS - 1)) begin
        ph_nxt = P_IDLE; sts.walk_done = 1'b1;
      end
      P_PIX: ph_nxt = P_SQ;
      P_SQ: begin
        if (32'(s_r) > 32'(rr)) ph_nxt = P_NEXT;
        else begin
          sq_start = 1'b1; ph_nxt = P_SQW;
        end
      end
      P_SQW: if (sq_done) ph_nxt = P_RD;
      P_RD: ph_nxt = P_F1;
      P_F1: ph_nxt = P_F2;
      P_F2: ph_nxt = P_F3;
      P_F3: ph_nxt = mode ? P_B2 : P_WR;
      P_B2: ph_nxt = P_WR;
      P_WR: ph_nxt = P_NEXT;
      P_NEXT: begin
        if (x_r == x1_r && y_r == y1_r) begin
          ph_nxt = P_IDLE; sts.walk_done = 1'b1;
        end else begin
          ahead = 1'b1; ph_nxt = P_PIX;
        end
      end
      P_Q1: ph_nxt = P_Q2;
      P_Q2: ph_nxt = P_Q3;
      P_Q3: begin
        ph_nxt = P_IDLE; sts.query_done = 1'b1;
      end
      default: ph_nxt = P_IDLE;
    endcase
  end

  // reset starts a zeroing pass over the whole map
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= P_CLR;
      init_r <= 1'b1;
      clr_r <= '0;
    end else begin
      ph_r <= ph_nxt;
      if (ph_r == P_CLR) clr_r <= clr_r + AW'(1);
      else clr_r <= '0;
      if (ph_r == P_CLR && clr_r == AW'(CELLS - 1)) init_r <= 1'b0;
    end
  end

  assign hmag = hrd_r[31] ? 48'(-50'(hrd_r)) : 48'(hrd_r);
  assign smag = h_scl[24] ? 25'(-h_scl) : 25'(h_scl);

  always_ff @(posedge clk) begin
    case (ph_r)
      P_IDLE: begin
        lo_r <= lower;
        cx_r <= XW'(px);
        cy_r <= YW'(py);
        x0_r <= xl < 0 ? '0 : XW'(xl);
        x_r <= xl < 0 ? '0 : XW'(xl);
        y_r <= yl < 0 ? '0 : YW'(yl);
        x1_r <= xh > $signed({1'b0, 13'(XMAX)}) ? XMAX : XW'(xh);
        y1_r <= yh > $signed({1'b0, 13'(YMAX)}) ? YMAX : YW'(yh);
        addr_r <= AW'(py) * AW'(MAP_WIDTH) + AW'(px);
      end
      P_CLR: begin
        hmem[clr_r] <= init_r ? 32'sd0 : clr_h;
        bmem[clr_r] <= init_r ? 17'd0 :
                       (clr_b > hbs_pkg::ONE_Q16) ? hbs_pkg::ONE_Q16 : clr_b;
      end
      P_PIX: begin
        s_r <= 18'(28'(dx) * 28'(dx) + 28'(dy) * 28'(dy));
        addr_r <= AW'(y_r) * AW'(MAP_WIDTH) + AW'(x_r);
      end
      P_RD: begin
        hrd_r <= hmem[addr_r];
        brd_r <= bmem[addr_r];
        f_r <= hbs_pkg::ONE_Q16 - dn;
      end
      P_F1: t_r <= 34'(f_r) * 34'(f_r);
      P_F2: t_r <= 34'(t_r[32:16]) * 34'(k3);
      P_F3: begin
        g_r <= t_r[32:16];
        p_r <= mode ? 64'(dmag) * 64'(b_str) : 64'(h_str) * 64'(t_r[32:16]);
      end
      P_B2: p_r <= 64'(p_r[34:0]) * 64'(g_r);
      P_WR: begin
        if (!mode) hmem[addr_r] <= hwr;
        else bmem[addr_r] <= bwr;
      end
      P_NEXT: if (ahead) begin
        if (x_r == x1_r) begin
          x_r <= x0_r; y_r <= y_r + YW'(1);
        end else x_r <= x_r + XW'(1);
      end
      P_Q1: hrd_r <= hmem[addr_r];
      P_Q2: begin
        neg_r <= hrd_r[31] ^ h_scl[24];
        qprod_r <= 64'(hmag[31:0]) * 64'(smag);
      end
      P_Q3: begin
        hv_r <= neg_r ? -48'(qprod_r[63:16]) : 48'(qprod_r[63:16]);
      end
      default: ;
    endcase
  end

  assign height_value = hv_r;
endmodule

>>> rtl/heightmap_brush_stamp_engine.sv
// Top level of the heightmap brush stamp engine.
//  channel | direction | handshake        | payload
//  in_     | input     | in_valid/stall   | operation, pos_u, pos_v, lower
//  out_    | output    | out_valid/stall  | reply_kind, applied, height_value
//  cfg_    | input     | cfg_valid/ready  | cfg_index, cfg_data
// One item at a time; in_stall is high from the accepting edge until the result
// beat leaves. Clear writes every map cell, one map write per cycle.
// Stamp walks each pixel of the clipped square; one inside the radius also runs
// the 25-step root and 25-step divide by radius; blend mode adds a multiply.
// Query reads and scales one cell; zero-radius stamp or unused code does no work.
// Reset zeroes the map in a pass over every cell, in_stall high.
// The result beat holds while out_stall is high.
`timescale 1ns / 1ps
module heightmap_brush_stamp_engine #(
  parameter int MAP_WIDTH  = hbs_pkg::MapWidthDef,
  parameter int MAP_HEIGHT = hbs_pkg::MapHeightDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic [16:0]        in_pos_u,
  input  logic [16:0]        in_pos_v,
  input  logic               in_lower,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_reply_kind,
  output logic               out_applied,
  output logic signed [47:0] out_height_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  logic mode_r;
  logic [8:0] rad_r;
  logic [16:0] hstr_r, bstr_r, btgt_r, clrb_r;
  logic signed [24:0] hscl_r;
  logic signed [31:0] clrh_r;
  hbs_pkg::cmd_t cmd;
  hbs_pkg::sts_t sts;
  logic signed [47:0] hv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0; rad_r <= 9'd1; hstr_r <= 17'd655; bstr_r <= 17'd655;
      btgt_r <= '0; hscl_r <= 25'sd65536; clrh_r <= '0; clrb_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        hbs_pkg::REG_MODE:   mode_r <= cfg_data[0];
        hbs_pkg::REG_RADIUS: rad_r <= cfg_data[8:0];
        hbs_pkg::REG_HSTR:   hstr_r <= cfg_data[16:0];
        hbs_pkg::REG_BSTR:   bstr_r <= cfg_data[16:0];
        hbs_pkg::REG_BTGT:   btgt_r <= cfg_data[16:0];
        hbs_pkg::REG_HSCL:   hscl_r <= cfg_data[24:0];
        hbs_pkg::REG_CLRH:   clrh_r <= cfg_data;
        hbs_pkg::REG_CLRB:   clrb_r <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  hbs_ctrl u_ctrl (.clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(in_operation), .radius_zero(rad_r == 9'd0), .out_valid(out_valid),
    .out_stall(out_stall), .kind(out_reply_kind), .applied(out_applied),
    .cmd(cmd), .sts(sts));

  // the datapath latches position and lower at the accepting edge
  hbs_datapath #(.MAP_WIDTH(MAP_WIDTH), .MAP_HEIGHT(MAP_HEIGHT)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .pos_u(in_pos_u), .pos_v(in_pos_v),
    .lower(in_lower), .mode(mode_r), .radius(rad_r), .h_str(hstr_r), .h_scl(hscl_r),
    .b_str(bstr_r), .b_tgt(btgt_r), .clr_h(clrh_r), .clr_b(clrb_r),
    .height_value(hv));

  assign out_height_value = (out_reply_kind == hbs_pkg::OP_QUERY) ? hv : 48'sd0;
endmodule
